[rtl/core/rcps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_pkg
// Shared sizes, codes and types for the credit-based output port selector.
// ----------------------------------------------------------------------------
package rcps_pkg;

    localparam int NUM_PORTS    = 5;
    localparam int NUM_VCS      = 4;
    localparam int CREDIT_WIDTH = 4;
    localparam int COORD_WIDTH  = 4;

    localparam int NUM_ENTRIES  = NUM_PORTS * NUM_VCS;
    localparam int ELIG_W       = 20;
    localparam int PORT_W       = 3;
    localparam int VC_W         = 2;
    localparam int ENTRY_W      = $clog2(NUM_ENTRIES);
    localparam int SCORE_W      = CREDIT_WIDTH + $clog2(NUM_VCS + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic CMD_SELECT = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_DIM_PORTS = 2'd2;

    typedef logic [NUM_PORTS-1:0]    port_mask_t;
    typedef logic [SCORE_W-1:0]      score_t;
    typedef logic [CREDIT_WIDTH-1:0] credit_t;
    typedef logic [COORD_WIDTH-1:0]  coord_t;

endpackage

[rtl/core/router_credit_based_port_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// router_credit_based_port_select
// O1TURN-style output port selector: keeps downstream VC availability and
// credits; picks the best-scoring port at the source, else the highest one.
// ----------------------------------------------------------------------------
// A select result reaches done through the input and result registers.
// Throughput: one item per cycle; busy stays low, start is always taken.
// Update items produce no result; a select issued the next cycle sees them.
// Result pipe is input register -> scoring/argmax logic -> result register.
// Reset clears the VC tables, configuration and all strobes asynchronously.
module router_credit_based_port_select
    import rcps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [NUM_PORTS-1:0]  route_mask,
    input  logic [ELIG_W-1:0]     vc_eligible,
    input  logic [COORD_WIDTH-1:0] src_x,
    input  logic [COORD_WIDTH-1:0] src_y,
    input  logic [PORT_W-1:0]     upd_port,
    input  logic [VC_W-1:0]       upd_vc,
    input  logic                  upd_avail,
    input  logic [CREDIT_WIDTH-1:0] upd_credits,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [PORT_W-1:0]     out_port,
    output logic                  y_first,
    output logic                  adaptive,
    output logic                  no_route
);

    coord_t     local_x_reg;
    coord_t     local_y_reg;
    port_mask_t x_dim_ports_reg;

    logic                  in_valid_reg;
    logic                  cmd_reg;
    port_mask_t            mask_reg;
    logic [ELIG_W-1:0]     elig_reg;
    coord_t                src_x_reg;
    coord_t                src_y_reg;
    logic [PORT_W-1:0]     upd_port_reg;
    logic [VC_W-1:0]       upd_vc_reg;
    logic                  upd_avail_reg;
    credit_t               upd_credits_reg;

    logic    avail_reg  [NUM_ENTRIES];
    credit_t credit_reg [NUM_ENTRIES];

    logic                  done_reg;
    logic [PORT_W-1:0]     out_port_reg;
    logic                  y_first_reg;
    logic                  adaptive_reg;
    logic                  no_route_reg;

    logic                  upd_en;
    logic [ENTRY_W-1:0]    upd_idx;
    score_t                score [NUM_PORTS];
    logic                  sel_valid;
    logic                  at_source;
    logic                  multi;
    logic [PORT_W-1:0]     port_next;
    logic                  y_first_next;
    logic                  adaptive_next;
    logic                  no_route_next;
    logic [PORT_W-1:0]     best_port;
    logic [PORT_W-1:0]     high_port;
    score_t                best_score;
    logic                  have;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_x_reg     <= '0;
            local_y_reg     <= '0;
            x_dim_ports_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LOCAL_X:     local_x_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_LOCAL_Y:     local_y_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_X_DIM_PORTS: x_dim_ports_reg <= cfg_data[NUM_PORTS-1:0];
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg         <= command;
            mask_reg        <= route_mask;
            elig_reg        <= vc_eligible;
            src_x_reg       <= src_x;
            src_y_reg       <= src_y;
            upd_port_reg    <= upd_port;
            upd_vc_reg      <= upd_vc;
            upd_avail_reg   <= upd_avail;
            upd_credits_reg <= upd_credits;
        end
    end

    // VC status table
    assign upd_en  = in_valid_reg && (cmd_reg == CMD_UPDATE)
                     && (int'(upd_port_reg) < NUM_PORTS) && (int'(upd_vc_reg) < NUM_VCS);
    assign upd_idx = ENTRY_W'(upd_port_reg) * ENTRY_W'(NUM_VCS) + ENTRY_W'(upd_vc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                avail_reg[e]  <= 1'b0;
                credit_reg[e] <= '0;
            end
        end
        else if (upd_en)
        begin
            avail_reg[upd_idx]  <= upd_avail_reg;
            credit_reg[upd_idx] <= upd_credits_reg;
        end
    end

    // per-port scores
    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            score[p] = '0;
            for (int v = 0; v < NUM_VCS; v++)
            begin
                if ((p * NUM_VCS + v) < ELIG_W)
                begin
                    if (elig_reg[p * NUM_VCS + v] && avail_reg[p * NUM_VCS + v])
                        score[p] = score[p] + SCORE_W'(credit_reg[p * NUM_VCS + v]);
                end
            end
        end
    end

    // port choice
    always_comb
    begin
        sel_valid = in_valid_reg && (cmd_reg == CMD_SELECT);
        at_source = (src_x_reg == local_x_reg) && (src_y_reg == local_y_reg);
        multi     = $countones(mask_reg) > 1;

        have       = 1'b0;
        best_score = '0;
        best_port  = '0;
        high_port  = '0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (mask_reg[p])
            begin
                high_port = PORT_W'(p);
                if (!have || (score[p] > best_score))
                begin
                    have       = 1'b1;
                    best_score = score[p];
                    best_port  = PORT_W'(p);
                end
            end
        end

        no_route_next = (mask_reg == '0);
        adaptive_next = !no_route_next && at_source && multi;
        port_next     = adaptive_next ? best_port : high_port;
        y_first_next  = adaptive_next && !x_dim_ports_reg[best_port];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sel_valid)
        begin
            out_port_reg <= port_next;
            y_first_reg  <= y_first_next;
            adaptive_reg <= adaptive_next;
            no_route_reg <= no_route_next;
        end
    end

    assign done     = done_reg;
    assign out_port = out_port_reg;
    assign y_first  = y_first_reg;
    assign adaptive = adaptive_reg;
    assign no_route = no_route_reg;

    // checks
    a_done_follows_select: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(sel_valid))
        else $error("result without a select transfer");

    a_no_route_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && no_route_reg) |-> (out_port_reg == '0 && !adaptive_reg && !y_first_reg))
        else $error("no_route result carries a port");

    a_adaptive_needs_choice: assert property (@(posedge clk) disable iff (!rst_n)
        sel_valid && adaptive_next |-> ($countones(mask_reg) > 1) && mask_reg[port_next])
        else $error("adaptive pick outside candidate set");

    a_port_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (int'(out_port_reg) < NUM_PORTS))
        else $error("selected port out of range");

endmodule
